>>> src/scc_pkg.sv
// Shared widths and the per-item control bundle for the consensus counter.
`default_nettype none
package scc_pkg;

  localparam int BASE_W    = 2;
  localparam int SHIFT_W   = 7;
  localparam int POS_W     = 7;
  localparam int NUM_BASES = 4;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              restart;
    logic              last;
    logic [POS_W-1:0]  position;
  } item_ctl_t;

endpackage
`default_nettype wire

>>> src/scc_front.sv
// Position counter, latched read mode and source address generation.
`default_nettype none
module scc_front #(
  parameter int READ_LEN = 100,
  parameter int IDX_W    = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [scc_pkg::BASE_W-1:0]  base,
  input  wire logic                        first,
  input  wire logic                        start_new,
  input  wire logic                        complement,
  input  wire logic [scc_pkg::SHIFT_W-1:0] shift,
  output scc_pkg::item_ctl_t               ctl,
  output logic [IDX_W-1:0]                 idx,
  output logic                             rd_en,
  output logic [IDX_W-1:0]                 rd_addr
);

  localparam int SRC_W = ((IDX_W > scc_pkg::SHIFT_W) ? IDX_W : scc_pkg::SHIFT_W) + 1;

  logic [IDX_W-1:0]            pos_counter;
  logic                        lat_start_new;
  logic                        lat_complement;
  logic [scc_pkg::SHIFT_W-1:0] lat_shift;

  logic                        cur_start_new;
  logic                        cur_complement;
  logic [scc_pkg::SHIFT_W-1:0] cur_shift;
  logic [IDX_W-1:0]            pos;
  logic [SRC_W-1:0]            src;
  logic                        restart;

  always_comb begin
    cur_start_new  = first ? start_new  : lat_start_new;
    cur_complement = first ? complement : lat_complement;
    cur_shift      = first ? shift      : lat_shift;
    pos            = first ? '0 : pos_counter;
    src            = SRC_W'(pos) + SRC_W'(cur_shift);
    restart        = cur_start_new || (src >= SRC_W'(READ_LEN));
    ctl.base       = cur_complement ? (scc_pkg::BASE_W'(scc_pkg::NUM_BASES - 1) - base) : base;
    ctl.restart    = restart;
    ctl.last       = (pos == IDX_W'(READ_LEN - 1));
    ctl.position   = scc_pkg::POS_W'(pos);
    idx            = pos;
    rd_en          = accept && !restart;
    rd_addr        = src[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_counter    <= '0;
      lat_start_new  <= 1'b0;
      lat_complement <= 1'b0;
      lat_shift      <= '0;
    end else if (accept) begin
      pos_counter <= (pos == IDX_W'(READ_LEN - 1)) ? '0 : pos + IDX_W'(1);
      if (first) begin
        lat_start_new  <= start_new;
        lat_complement <= complement;
        lat_shift      <= shift;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/scc_count_mem.sv
// Base count memory with per-entry valid bits and write-to-read forwarding.
`default_nettype none
module scc_count_mem #(
  parameter int READ_LEN = 100,
  parameter int IDX_W    = 7,
  parameter int WORD_W   = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic [WORD_W-1:0]      rd_data
);

  logic [WORD_W-1:0]   mem [READ_LEN];
  logic [READ_LEN-1:0] valid;
  logic [WORD_W-1:0]   rd_raw;
  logic                rd_valid;
  logic                fwd_hit;
  logic [WORD_W-1:0]   fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw   <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : (rd_valid ? rd_raw : '0);

endmodule
`default_nettype wire

>>> src/scc_vote.sv
// Saturating count update and plurality vote (ties go to the lowest base) for one position.
`default_nettype none
module scc_vote #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic [4*COUNT_BITS-1:0]     word_in,
  input  wire logic [scc_pkg::BASE_W-1:0]  base,
  input  wire logic                        restart,
  output logic [4*COUNT_BITS-1:0]          word_out,
  output logic [scc_pkg::BASE_W-1:0]       best
);

  logic [COUNT_BITS-1:0]      cnt [scc_pkg::NUM_BASES];
  logic [COUNT_BITS-1:0]      best_val;

  always_comb begin
    for (int b = 0; b < scc_pkg::NUM_BASES; b++) begin
      if (restart) begin
        cnt[b] = (scc_pkg::BASE_W'(b) == base) ? COUNT_BITS'(1) : '0;
      end else begin
        cnt[b] = word_in[b*COUNT_BITS +: COUNT_BITS];
        if (scc_pkg::BASE_W'(b) == base && cnt[b] != '1) begin
          cnt[b] = cnt[b] + COUNT_BITS'(1);
        end
      end
    end
    best     = '0;
    best_val = '0;
    for (int b = 0; b < scc_pkg::NUM_BASES; b++) begin
      word_out[b*COUNT_BITS +: COUNT_BITS] = cnt[b];
      if (cnt[b] > best_val) begin
        best_val = cnt[b];
        best     = scc_pkg::BASE_W'(b);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/shifted_consensus_counter.sv
// Top level of the shifted consensus counter: stream ports, pipeline and result register.
// Each accepted base yields exactly one consensus result, held in the b stage and then
// in the result register; one base is taken every cycle while the result sink keeps up.
// The count store has one read and one write port: a base reads the counters at
// position + shift when taken and writes its own position when it leaves the b stage;
// a write to the address being read in the same cycle is forwarded. Per-entry valid
// bits make the store read zero after reset; no clearing pass runs, ready at once.
`default_nettype none
module shifted_consensus_counter #(
  parameter int READ_LEN   = 100,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // base[1:0], shift[8:2], zero[15:9]
  input  wire logic [2:0]  s_tuser,   // first[0], start_new[1], complement[2]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // consensus_base[1:0], position[8:2], zero[15:9]
  output logic             m_tlast
);

  localparam int IDX_W  = (READ_LEN > 1) ? $clog2(READ_LEN) : 1;
  localparam int WORD_W = scc_pkg::NUM_BASES * COUNT_BITS;

  logic                        accept;
  scc_pkg::item_ctl_t          in_ctl;
  logic [IDX_W-1:0]            in_idx;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;

  logic                        b_v;
  scc_pkg::item_ctl_t          b_ctl;
  logic [IDX_W-1:0]            b_idx;
  logic                        b_adv;
  logic [WORD_W-1:0]           rd_data;
  logic [WORD_W-1:0]           word_new;
  logic [scc_pkg::BASE_W-1:0]  vote_best;

  logic                        o_v;
  logic [scc_pkg::BASE_W-1:0]  o_base;
  logic [scc_pkg::POS_W-1:0]   o_pos;
  logic                        o_last;

  assign b_adv    = b_v && (!o_v || m_tready);
  assign s_tready = !b_v || b_adv;
  assign accept   = s_tvalid && s_tready;

  scc_front #(
    .READ_LEN (READ_LEN),
    .IDX_W    (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .base       (s_tdata[1:0]),
    .first      (s_tuser[0]),
    .start_new  (s_tuser[1]),
    .complement (s_tuser[2]),
    .shift      (s_tdata[8:2]),
    .ctl        (in_ctl),
    .idx        (in_idx),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  scc_count_mem #(
    .READ_LEN (READ_LEN),
    .IDX_W    (IDX_W),
    .WORD_W   (WORD_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (b_adv),
    .wr_addr (b_idx),
    .wr_data (word_new),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scc_vote #(
    .COUNT_BITS (COUNT_BITS)
  ) u_vote (
    .word_in  (rd_data),
    .base     (b_ctl.base),
    .restart  (b_ctl.restart),
    .word_out (word_new),
    .best     (vote_best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (accept) begin
      b_v <= 1'b1;
    end else if (b_adv) begin
      b_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_ctl <= in_ctl;
      b_idx <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (b_adv) begin
      o_v <= 1'b1;
    end else if (m_tready) begin
      o_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      o_base <= vote_best;
      o_pos  <= b_ctl.position;
      o_last <= b_ctl.last;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {7'b0, o_pos, o_base};
  assign m_tlast  = o_last;

  a_last_pos : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[8:2] == scc_pkg::POS_W'(READ_LEN - 1))
    else $error("last flag on a position other than the window end");

  a_stage_hold : assert property (@(posedge clk) disable iff (rst)
    b_v && !b_adv |=> b_v && $stable(b_ctl))
    else $error("pending item lost while the result register is full");

  a_restart_vote : assert property (@(posedge clk) disable iff (rst)
    b_v && b_ctl.restart |-> vote_best == b_ctl.base)
    else $error("restarted position does not vote for its own base");

endmodule
`default_nettype wire

>>> bench/consensus_checker.sv
// Checker for the shifted consensus counter: tracks per-position base tallies and compares results.
`timescale 1ns / 1ps
module consensus_checker #(
  parameter int READ_LEN   = 100,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,   // base[1:0], shift[8:2], zero[15:9]
  input  wire logic [2:0]  s_tuser,   // first[0], start_new[1], complement[2]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,   // consensus_base[1:0], position[8:2], zero[15:9]
  input  wire logic        m_tlast,
  output int               fails,
  output int               pending
);

  typedef logic [scc_pkg::NUM_BASES-1:0][COUNT_BITS-1:0] tally_t;

  typedef struct packed {
    logic [scc_pkg::BASE_W-1:0] base;
    logic [scc_pkg::POS_W-1:0]  position;
    logic                       last;
  } call_t;

  localparam logic [COUNT_BITS-1:0] SAT = '1;

  tally_t                       tally [READ_LEN];
  int                           next_pos;
  logic                         lat_fresh;
  logic                         lat_comp;
  logic [scc_pkg::SHIFT_W-1:0]  lat_shift;
  call_t                        calls_due [$];
  int                           err_count = 0;

  function automatic call_t vote(input logic [scc_pkg::BASE_W-1:0] raw, input logic first,
                                 input logic fresh, input logic comp,
                                 input logic [scc_pkg::SHIFT_W-1:0] sh);
    call_t                      c;
    tally_t                     w;
    logic [scc_pkg::BASE_W-1:0] b;
    logic [scc_pkg::BASE_W-1:0] best;
    logic [COUNT_BITS-1:0]      top;
    int                         p;
    int                         src;
    if (first) begin
      lat_fresh = fresh;
      lat_comp  = comp;
      lat_shift = sh;
      next_pos  = 0;
    end
    if (next_pos >= READ_LEN) next_pos = 0;
    p = next_pos;
    b = lat_comp ? ~raw : raw;
    src = p + int'(lat_shift);
    if (lat_fresh || src >= READ_LEN) begin
      w    = '0;
      w[b] = COUNT_BITS'(1);
      best = b;
    end else begin
      w = tally[src];
      if (w[b] != SAT) w[b] = w[b] + COUNT_BITS'(1);
      best = '0;
      top  = '0;
      for (int k = 0; k < scc_pkg::NUM_BASES; k++) begin
        if (w[k] > top) begin
          top  = w[k];
          best = scc_pkg::BASE_W'(k);
        end
      end
    end
    tally[p]   = w;
    c.base     = best;
    c.position = scc_pkg::POS_W'(p);
    c.last     = (p == READ_LEN - 1);
    next_pos   = (p + 1 >= READ_LEN) ? 0 : p + 1;
    return c;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    call_t want;
    if (rst) begin
      for (int i = 0; i < READ_LEN; i++) tally[i] = '0;
      next_pos  = 0;
      lat_fresh = 1'b0;
      lat_comp  = 1'b0;
      lat_shift = '0;
      calls_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (calls_due.size() == 0) begin
          $error("result transfer with no consensus call pending: data %h last %b",
                 m_tdata, m_tlast);
          err_count++;
        end else begin
          want = calls_due.pop_front();
          check_field("consensus_base", want.base, m_tdata[1:0]);
          check_field("position", want.position, m_tdata[8:2]);
          check_field("last", want.last, m_tlast);
          check_field("tdata padding", 0, m_tdata[15:9]);
        end
      end
      if (s_tvalid && s_tready)
        calls_due.push_back(vote(s_tdata[1:0], s_tuser[0], s_tuser[1], s_tuser[2],
                                 s_tdata[8:2]));
    end
    pending <= calls_due.size();
    fails   <= err_count;
  end

endmodule

>>> bench/tb.sv
// Top of the consensus counter bench: clock, reset, base stimulus, result sink and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int READ_LEN     = 100;
  localparam int COUNT_BITS   = 16;
  localparam int GENOME_LEN   = 4096;
  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_CYCLES  = 200;
  localparam int WATCHDOG     = 2000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire         m_tlast;

  int fails;
  int pending;
  int gap_max     = 14;
  int stall_max   = 14;
  int holds_asked = 0;
  int holds_done  = 0;
  int idle_run    = 0;
  int items_sent  = 0;
  int offset      = 0;

  logic [scc_pkg::BASE_W-1:0] genome [GENOME_LEN];

  always #5 clk = ~clk;

  shifted_consensus_counter #(
    .READ_LEN  (READ_LEN),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  consensus_checker #(
    .READ_LEN  (READ_LEN),
    .COUNT_BITS(COUNT_BITS)
  ) chk (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .fails   (fails),
    .pending (pending)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(input logic [scc_pkg::BASE_W-1:0] b, input logic first,
                      input logic fresh, input logic comp,
                      input logic [scc_pkg::SHIFT_W-1:0] sh);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, sh, b};
    s_tuser  <= {comp, fresh, first};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Feed one read taken from the genome, with a few base errors.
  task automatic send_read(input int len, input logic fresh, input logic comp,
                           input logic [scc_pkg::SHIFT_W-1:0] sh);
    logic [scc_pkg::BASE_W-1:0] b;
    if (fresh) offset = $urandom_range(GENOME_LEN - 1, 0);
    else offset = (offset + sh) % GENOME_LEN;
    for (int i = 0; i < len; i++) begin
      b = genome[(offset + i) % GENOME_LEN];
      if ($urandom_range(9, 0) == 0) b = scc_pkg::BASE_W'($urandom);
      if (comp) b = ~b;
      if (i == 0) send(b, 1'b1, fresh, comp, sh);
      else send(b, 1'b0, 1'($urandom), 1'($urandom), scc_pkg::SHIFT_W'($urandom));
    end
  endtask

  initial begin : sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < holds_asked) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      stall = $urandom_range(stall_max, 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : source
    int   len;
    int   pick;
    bit   held;
    bit   paused;
    logic fresh;
    logic comp;
    logic [scc_pkg::SHIFT_W-1:0] sh;
    held   = 1'b0;
    paused = 1'b0;
    for (int i = 0; i < GENOME_LEN; i++) genome[i] = scc_pkg::BASE_W'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset mode applies before any first mark
    send(2'd0, 1'b0, 1'b1, 1'b1, 7'd127);
    send(2'd3, 1'b0, 1'b0, 1'b1, 7'd0);
    send(2'd1, 1'b0, 1'b1, 1'b0, 7'd5);
    // fresh read
    send(2'd3, 1'b1, 1'b1, 1'b0, 7'd0);
    send(2'd2, 1'b0, 1'b0, 1'b0, 7'd0);
    send(2'd0, 1'b0, 1'b1, 1'b1, 7'd0);
    // merge in place: ties go to the lowest base
    send(2'd0, 1'b1, 1'b0, 1'b0, 7'd0);
    send(2'd2, 1'b0, 1'b0, 1'b0, 7'd0);
    send(2'd1, 1'b0, 1'b0, 1'b0, 7'd0);
    // complemented merge, shifted by one
    send(2'd0, 1'b1, 1'b0, 1'b1, 7'd1);
    send(2'd1, 1'b0, 1'b0, 1'b0, 7'd0);
    send(2'd2, 1'b0, 1'b0, 1'b0, 7'd0);
    send(2'd3, 1'b0, 1'b0, 1'b0, 7'd0);
    // shift past the window
    send(2'd2, 1'b1, 1'b0, 1'b0, 7'd127);
    send(2'd1, 1'b0, 1'b0, 1'b0, 7'd0);
    send(2'd3, 1'b1, 1'b0, 1'b0, 7'd100);
    // shift that runs off the end after the first position
    send(2'd1, 1'b1, 1'b0, 1'b0, 7'd99);
    send(2'd0, 1'b0, 1'b0, 1'b0, 7'd0);
    send(2'd3, 1'b0, 1'b0, 1'b0, 7'd0);
    // fresh complemented read
    send(2'd0, 1'b1, 1'b1, 1'b1, 7'd64);
    send(2'd3, 1'b0, 1'b0, 1'b0, 7'd0);
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      gap_max   = ($urandom_range(3, 0) == 0) ? 0 : 14;
      stall_max = ($urandom_range(3, 0) == 0) ? 0 : 14;
      if (!held && items_sent >= 500) begin
        held = 1'b1;
        holds_asked++;
      end
      if (!paused && items_sent >= 1200) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        send(scc_pkg::BASE_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
             scc_pkg::SHIFT_W'($urandom));
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 60) len = READ_LEN;
        else if (pick < 85) len = $urandom_range(READ_LEN - 1, 1);
        else len = $urandom_range(READ_LEN + 30, READ_LEN + 1);
        fresh = ($urandom_range(4, 0) == 0);
        comp  = ($urandom_range(2, 0) == 0);
        if ($urandom_range(3, 0) == 0) sh = scc_pkg::SHIFT_W'($urandom_range(127, 0));
        else sh = scc_pkg::SHIFT_W'($urandom_range(12, 0));
        send_read(len, fresh, comp, sh);
      end
    end
    drain();

    repeat (10) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
